@@ rtl/psu_pkg.sv @@
// ----------------------------------------------------------------------------
// Particle state update: shared package
// Widths, register indexes, stage records and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package psu_pkg;

  // Vector component width and time fraction bits.
  localparam int CompWidth    = 16;
  localparam int TimeFracBits = 10;
  localparam int VecWidth     = 3 * CompWidth;

  // Product widths: accel * dt, rate * dt, component * dt.
  localparam int AccProdW  = 33;
  localparam int RateProdW = 41;
  localparam int VelProdW  = CompWidth + 17;

  // Divider geometry.
  localparam int DivDvdW  = 32;
  localparam int DivDsrW  = 16;
  localparam int DivBits  = 4;
  localparam int DivStg   = DivDvdW / DivBits;

  // Stages from the first window stage to the divider output.
  localparam int SideDepth = DivStg + 1;
  // Motion output arrives three stages in, then waits for the divider.
  localparam int MotDelay  = SideDepth - 3;

  localparam int WideW = 40;

  typedef enum logic [2:0] {
    REG_FRAME_TIME  = 3'd0,
    REG_ACCEL_X     = 3'd1,
    REG_ACCEL_Y     = 3'd2,
    REG_ACCEL_Z     = 3'd3,
    REG_GROW_TIME   = 3'd4,
    REG_SHRINK_TIME = 3'd5,
    REG_FADE_TIME   = 3'd6
  } cfg_reg_t;

  typedef logic signed [AccProdW-1:0] acc_prod_t;

  // Per-item record that travels beside the divider.
  typedef struct packed {
    logic                 valid;
    logic                 dead;
    logic                 grow_f;
    logic                 shrink_f;
    logic                 fade_f;
    logic [15:0]          nage;
    logic [31:0]          pfull;
    logic [15:0]          size;
    logic [15:0]          full;
    logic [12:0]          alpha;
    logic [VecWidth-1:0]  vel;
    logic [VecWidth-1:0]  pos;
    logic [23:0]          ang;
  } side_t;

  // Motion results held until the divider catches up.
  typedef struct packed {
    logic [VecWidth-1:0] vel;
    logic [VecWidth-1:0] pos;
    logic [23:0]         ang;
  } mot_t;

  // Saturate a wide signed value to one vector component.
  function automatic logic [CompWidth-1:0] sat_comp(input logic signed [WideW-1:0] x);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = WideW'((64'sd1 <<< (CompWidth - 1)) - 64'sd1);
    lo = -hi - WideW'(1);
    if (x > hi) return hi[CompWidth-1:0];
    if (x < lo) return lo[CompWidth-1:0];
    return x[CompWidth-1:0];
  endfunction

  // Saturate a wide signed value to the 24-bit angle.
  function automatic logic [23:0] sat_ang(input logic signed [WideW-1:0] x);
    if (x > WideW'(40'sd8388607)) return 24'h7FFFFF;
    if (x < -WideW'(40'sd8388608)) return 24'h800000;
    return x[23:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/particle_state_update_top.sv @@
// ----------------------------------------------------------------------------
// Particle state update: top level
// Advances one particle record per cycle, unless the receiver stalls, by the configured frame time.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one particle record per transfer; the out_ channel
//   returns exactly one updated record per input, in order. Both use valid and
//   ready. The cfg_ channel writes one register by index and is always ready;
//   write it only while no particle is in flight.
//   Throughput is one record per cycle while the receiver takes results, set by
//   the fully pipelined path: a capture stage with the multipliers, a window
//   stage, an eight-stage size and alpha divider at four quotient bits per
//   stage, and the output register. The motion path runs beside the divider
//   and waits in a short delay line.
//   Reset clears all valid bits and loads the register defaults (frame time
//   16, all others 0). When the receiver stalls, the whole pipeline holds;
//   in_ready drops only while the output register is full and not taken, so
//   nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_state_update_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [15:0]                  in_age,
  input  wire logic [15:0]                  in_lifetime,
  input  wire logic [psu_pkg::VecWidth-1:0] in_velocity,
  input  wire logic [psu_pkg::VecWidth-1:0] in_position,
  input  wire logic signed [23:0]           in_angle,
  input  wire logic signed [23:0]           in_angular_rate,
  input  wire logic [15:0]                  in_size,
  input  wire logic [15:0]                  in_full_size,
  input  wire logic [12:0]                  in_alpha,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_alive,
  output logic [15:0]                       out_new_age,
  output logic [psu_pkg::VecWidth-1:0]      out_new_velocity,
  output logic [psu_pkg::VecWidth-1:0]      out_new_position,
  output logic signed [23:0]                out_new_angle,
  output logic [15:0]                       out_new_size,
  output logic [12:0]                       out_new_alpha,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [2:0]                   cfg_index,
  input  wire logic [15:0]                  cfg_data
);
  import psu_pkg::*;

  logic        en;
  logic [15:0] frame_time_r;
  logic [15:0] accel_r [3];
  logic [15:0] grow_time_r;
  logic [15:0] shrink_time_r;
  logic [15:0] fade_time_r;

  // Capture stage.
  logic                        v0_r;
  logic [15:0]                 nage0_r;
  logic [15:0]                 life0_r;
  logic [VecWidth-1:0]         vel0_r;
  logic [VecWidth-1:0]         pos0_r;
  logic [23:0]                 ang0_r;
  logic [15:0]                 size0_r;
  logic [15:0]                 full0_r;
  logic [12:0]                 alpha0_r;
  acc_prod_t                   pacc0_r [3];
  logic signed [RateProdW-1:0] prate0_r;
  logic [31:0]                 pfull0_r;
  logic [16:0]                 nage_sum;
  acc_prod_t                   pacc_nxt [3];
  logic signed [RateProdW-1:0] prate_nxt;
  logic signed [16:0]          dt_s;

  side_t side_r   [SideDepth];
  side_t side_nxt;
  mot_t  mot;
  mot_t  mot_r    [MotDelay];

  logic [DivDvdW-1:0] q_size;
  logic [DivDvdW-1:0] q_alpha;
  logic [DivDsrW-1:0] size_dsr;

  logic [15:0] size_nxt;
  logic [12:0] alpha_nxt;
  logic        out_valid_r;

  // Whole pipeline moves unless the output register holds an untaken result.
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_time_r  <= 16'd16;
      accel_r[0]    <= '0;
      accel_r[1]    <= '0;
      accel_r[2]    <= '0;
      grow_time_r   <= '0;
      shrink_time_r <= '0;
      fade_time_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_TIME:  frame_time_r  <= cfg_data;
        REG_ACCEL_X:     accel_r[0]    <= cfg_data;
        REG_ACCEL_Y:     accel_r[1]    <= cfg_data;
        REG_ACCEL_Z:     accel_r[2]    <= cfg_data;
        REG_GROW_TIME:   grow_time_r   <= cfg_data;
        REG_SHRINK_TIME: shrink_time_r <= cfg_data;
        REG_FADE_TIME:   fade_time_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturated age and the frame-time products.
  assign dt_s     = signed'({1'b0, frame_time_r});
  assign nage_sum = {1'b0, in_age} + {1'b0, frame_time_r};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pacc_nxt[j] = signed'(accel_r[j]) * dt_s;
    end
    prate_nxt = in_angular_rate * dt_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nage0_r  <= nage_sum[16] ? 16'hFFFF : nage_sum[15:0];
      life0_r  <= in_lifetime;
      vel0_r   <= in_velocity;
      pos0_r   <= in_position;
      ang0_r   <= in_angle;
      size0_r  <= in_size;
      full0_r  <= in_full_size;
      alpha0_r <= in_alpha;
      pacc0_r  <= pacc_nxt;
      prate0_r <= prate_nxt;
      pfull0_r <= in_full_size * frame_time_r;
    end
  end

  // Life test and window decisions.
  always_comb begin
    side_nxt.valid    = v0_r;
    side_nxt.dead     = nage0_r > life0_r;
    side_nxt.grow_f   = nage0_r < grow_time_r;
    side_nxt.shrink_f = ({1'b0, nage0_r} + {1'b0, shrink_time_r}) > {1'b0, life0_r};
    side_nxt.fade_f   = ({1'b0, nage0_r} + {1'b0, fade_time_r}) > {1'b0, life0_r};
    side_nxt.nage     = nage0_r;
    side_nxt.pfull    = pfull0_r;
    side_nxt.size     = size0_r;
    side_nxt.full     = full0_r;
    side_nxt.alpha    = alpha0_r;
    side_nxt.vel      = vel0_r;
    side_nxt.pos      = pos0_r;
    side_nxt.ang      = ang0_r;
  end

  // Side record shift line, valid bits under reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SideDepth; s++) begin
        side_r[s].valid <= 1'b0;
      end
    end else if (en) begin
      side_r[0] <= side_nxt;
      for (int s = 1; s < SideDepth; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  // Size and alpha step divisions.
  assign size_dsr = side_r[0].grow_f ? grow_time_r : shrink_time_r;

  psu_div u_div_size (
    .clk      (clk),
    .en       (en),
    .dividend (side_r[0].pfull),
    .divisor  (size_dsr),
    .quotient (q_size)
  );

  psu_div u_div_alpha (
    .clk      (clk),
    .en       (en),
    .dividend ({4'b0, frame_time_r, 12'b0}),
    .divisor  (fade_time_r),
    .quotient (q_alpha)
  );

  // Motion path.
  psu_motion u_motion (
    .clk       (clk),
    .en        (en),
    .dt        (frame_time_r),
    .vel       (vel0_r),
    .pos       (pos0_r),
    .ang       (ang0_r),
    .acc_prod  (pacc0_r),
    .rate_prod (prate0_r),
    .mot       (mot)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      mot_r[0] <= mot;
      for (int s = 1; s < MotDelay; s++) begin
        mot_r[s] <= mot_r[s-1];
      end
    end
  end

  // Final size and alpha.
  always_comb begin
    logic [32:0] grown;
    side_t       sd;
    sd    = side_r[SideDepth-1];
    grown = {1'b0, q_size} + 33'(sd.size);
    if (sd.grow_f) begin
      size_nxt = (grown > 33'(sd.full)) ? sd.full : grown[15:0];
    end else if (sd.shrink_f) begin
      size_nxt = (q_size > 32'(sd.size)) ? 16'd0 : (sd.size - q_size[15:0]);
    end else begin
      size_nxt = sd.full;
    end
    if (sd.fade_f) begin
      alpha_nxt = (q_alpha > 32'(sd.alpha)) ? 13'd0 : (sd.alpha - q_alpha[12:0]);
    end else begin
      alpha_nxt = sd.alpha;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= side_r[SideDepth-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_alive   <= !side_r[SideDepth-1].dead;
      out_new_age <= side_r[SideDepth-1].nage;
      if (side_r[SideDepth-1].dead) begin
        out_new_velocity <= side_r[SideDepth-1].vel;
        out_new_position <= side_r[SideDepth-1].pos;
        out_new_angle    <= side_r[SideDepth-1].ang;
        out_new_size     <= side_r[SideDepth-1].size;
        out_new_alpha    <= side_r[SideDepth-1].alpha;
      end else begin
        out_new_velocity <= mot_r[MotDelay-1].vel;
        out_new_position <= mot_r[MotDelay-1].pos;
        out_new_angle    <= mot_r[MotDelay-1].ang;
        out_new_size     <= size_nxt;
        out_new_alpha    <= alpha_nxt;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/psu_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, four quotient bits per stage, one result per cycle while en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_div (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [psu_pkg::DivDvdW-1:0] dividend,
  input  wire logic [psu_pkg::DivDsrW-1:0] divisor,
  output logic      [psu_pkg::DivDvdW-1:0] quotient
);
  import psu_pkg::*;

  logic [DivDsrW-1:0] rem_r   [DivStg];
  logic [DivDvdW-1:0] dvd_r   [DivStg];
  logic [DivDsrW-1:0] dsr_r   [DivStg];
  logic [DivDsrW-1:0] rem_nxt [DivStg];
  logic [DivDvdW-1:0] dvd_nxt [DivStg];
  logic [DivDsrW-1:0] dsr_nxt [DivStg];

  // Each stage shifts in dividend bits and trial-subtracts the divisor.
  always_comb begin
    logic [DivDsrW-1:0] r;
    logic [DivDvdW-1:0] q;
    logic [DivDsrW-1:0] d;
    logic [DivDsrW:0]   t;
    for (int s = 0; s < DivStg; s++) begin
      if (s == 0) begin
        r = '0;
        q = dividend;
        d = divisor;
      end else begin
        r = rem_r[s-1];
        q = dvd_r[s-1];
        d = dsr_r[s-1];
      end
      for (int k = 0; k < DivBits; k++) begin
        t = {r, q[DivDvdW-1]};
        q = {q[DivDvdW-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
          t    = t - {1'b0, d};
          q[0] = 1'b1;
        end
        r = t[DivDsrW-1:0];
      end
      rem_nxt[s] = r;
      dvd_nxt[s] = q;
      dsr_nxt[s] = d;
    end
  end

  // Stage registers advance together with the rest of the pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DivStg; s++) begin
        rem_r[s] <= rem_nxt[s];
        dvd_r[s] <= dvd_nxt[s];
        dsr_r[s] <= dsr_nxt[s];
      end
    end
  end

  assign quotient = dvd_r[DivStg-1];

endmodule

`default_nettype wire

@@ rtl/psu_motion.sv @@
// ----------------------------------------------------------------------------
// Particle motion pipeline
// Velocity and angle update, velocity times dt, then position update.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_motion (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic [15:0]                          dt,
  input  wire logic [psu_pkg::VecWidth-1:0]         vel,
  input  wire logic [psu_pkg::VecWidth-1:0]         pos,
  input  wire logic [23:0]                          ang,
  input  wire psu_pkg::acc_prod_t                   acc_prod [3],
  input  wire logic signed [psu_pkg::RateProdW-1:0] rate_prod,
  output psu_pkg::mot_t                             mot
);
  import psu_pkg::*;

  logic [CompWidth-1:0]        vn1_r  [3];
  logic [VecWidth-1:0]         pos1_r;
  logic [23:0]                 ang1_r;
  logic signed [VelProdW-1:0]  vp2_r  [3];
  logic [CompWidth-1:0]        vn2_r  [3];
  logic [VecWidth-1:0]         pos2_r;
  logic [23:0]                 ang2_r;
  logic [VecWidth-1:0]         vel3_r;
  logic [VecWidth-1:0]         pos3_r;
  logic [23:0]                 ang3_r;
  logic [CompWidth-1:0]        vn1_nxt [3];
  logic [23:0]                 ang1_nxt;
  logic signed [VelProdW-1:0]  vp2_nxt [3];
  logic [VecWidth-1:0]         pos3_nxt;
  logic [VecWidth-1:0]         vel3_nxt;
  logic signed [16:0]          dt_s;

  assign dt_s = signed'({1'b0, dt});

  // Velocity and angle advance by the floored scaled products.
  always_comb begin
    logic signed [WideW-1:0] vv;
    logic signed [WideW-1:0] aa;
    for (int j = 0; j < 3; j++) begin
      vv = WideW'(signed'(vel[j*CompWidth +: CompWidth]))
         + WideW'(acc_prod[j] >>> TimeFracBits);
      vn1_nxt[j] = sat_comp(vv);
    end
    aa = WideW'(signed'(ang)) + WideW'(rate_prod >>> TimeFracBits);
    ang1_nxt = sat_ang(aa);
  end

  // New velocity times dt.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      vp2_nxt[j] = signed'(vn1_r[j]) * dt_s;
    end
  end

  // Position advances by the floored velocity product.
  always_comb begin
    logic signed [WideW-1:0] pp;
    for (int j = 0; j < 3; j++) begin
      pp = WideW'(signed'(pos2_r[j*CompWidth +: CompWidth]))
         + WideW'(vp2_r[j] >>> TimeFracBits);
      pos3_nxt[j*CompWidth +: CompWidth] = sat_comp(pp);
      vel3_nxt[j*CompWidth +: CompWidth] = vn2_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vn1_r  <= vn1_nxt;
      pos1_r <= pos;
      ang1_r <= ang1_nxt;
      vp2_r  <= vp2_nxt;
      vn2_r  <= vn1_r;
      pos2_r <= pos1_r;
      ang2_r <= ang1_r;
      vel3_r <= vel3_nxt;
      pos3_r <= pos3_nxt;
      ang3_r <= ang2_r;
    end
  end

  assign mot.vel = vel3_r;
  assign mot.pos = pos3_r;
  assign mot.ang = ang3_r;

endmodule

`default_nettype wire

@@ tb/tb_particle_state_update_top.sv @@
// ----------------------------------------------------------------------------
// Particle state update testbench
// Streams particle records through the block under several register settings
// and random handshake gaps. Each returned record is compared field by field
// with an in-bench prediction of the Euler update, aging, size and alpha fade.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_particle_state_update_top;
  import psu_pkg::*;

  localparam logic [2:0] REG_UNMAPPED = 3'd7;
  localparam int StallLimit = 4000;
  localparam int DrainCycles = 20;

  typedef struct packed {
    logic [15:0]         age;
    logic [15:0]         lifetime;
    logic [VecWidth-1:0] vel;
    logic [VecWidth-1:0] pos;
    logic [23:0]         ang;
    logic [23:0]         rate;
    logic [15:0]         size;
    logic [15:0]         full;
    logic [12:0]         alpha;
  } particle_t;

  typedef struct packed {
    logic                alive;
    logic [15:0]         age;
    logic [VecWidth-1:0] vel;
    logic [VecWidth-1:0] pos;
    logic [23:0]         ang;
    logic [15:0]         size;
    logic [12:0]         alpha;
  } update_t;

  typedef struct {
    particle_t p;
    logic      typed;
    update_t   r;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  logic [15:0] in_age, in_lifetime, in_size, in_full_size;
  logic [VecWidth-1:0] in_velocity, in_position;
  logic signed [23:0] in_angle, in_angular_rate;
  logic [12:0] in_alpha;
  logic out_valid, out_ready, out_alive;
  logic [15:0] out_new_age, out_new_size;
  logic [VecWidth-1:0] out_new_velocity, out_new_position;
  logic signed [23:0] out_new_angle;
  logic [12:0] out_new_alpha;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  // Shadow copy of the register file.
  logic [15:0] frame_time, grow_time, shrink_time, fade_time;
  logic [15:0] accel [3];

  update_t pending_updates[$];
  int errors;
  int idle_cycles;
  int send_gap_pct;
  int recv_stall_pct;

  particle_state_update_top DUT (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Saturate to a signed width.
  function automatic longint clamp_signed(longint x, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  function automatic longint to_signed(logic [63:0] v, int w);
    longint s;
    s = longint'(v & ((64'd1 << w) - 1));
    if (s >= (longint'(1) <<< (w - 1))) s -= (longint'(1) <<< w);
    return s;
  endfunction

  // Base plus floor(rate * dt / 2^frac), saturated.
  function automatic longint step_by_dt(longint base, longint rate, longint dt, int w);
    return clamp_signed(base + ((rate * dt) >>> TimeFracBits), w);
  endfunction

  // Expected record after one frame.
  function automatic update_t predict_update(particle_t p);
    update_t r;
    longint dt, nage, life, v, x, sz, full, al, ang;
    dt   = longint'(frame_time);
    life = longint'(p.lifetime);
    nage = longint'(p.age) + dt;
    if (nage > 65535) nage = 65535;
    r.age = nage[15:0];
    if (nage > life) begin
      r.alive = 1'b0;
      r.vel = p.vel;
      r.pos = p.pos;
      r.ang = p.ang;
      r.size = p.size;
      r.alpha = p.alpha;
      return r;
    end
    r.alive = 1'b1;
    for (int j = 0; j < 3; j++) begin
      v = to_signed(64'(p.vel[j*CompWidth +: CompWidth]), CompWidth);
      x = to_signed(64'(p.pos[j*CompWidth +: CompWidth]), CompWidth);
      v = step_by_dt(v, to_signed(64'(accel[j]), 16), dt, CompWidth);
      x = step_by_dt(x, v, dt, CompWidth);
      r.vel[j*CompWidth +: CompWidth] = v[CompWidth-1:0];
      r.pos[j*CompWidth +: CompWidth] = x[CompWidth-1:0];
    end
    ang = step_by_dt(to_signed(64'(p.ang), 24), to_signed(64'(p.rate), 24), dt, 24);
    r.ang = ang[23:0];
    sz = longint'(p.size);
    full = longint'(p.full);
    if (nage < longint'(grow_time)) begin
      sz += (full * dt) / longint'(grow_time);
      if (sz > full) sz = full;
    end else if (nage > life - longint'(shrink_time)) begin
      sz -= (full * dt) / longint'(shrink_time);
      if (sz < 0) sz = 0;
    end else begin
      sz = full;
    end
    r.size = sz[15:0];
    al = longint'(p.alpha);
    if (nage > life - longint'(fade_time)) begin
      al -= (dt * 4096) / longint'(fade_time);
      if (al < 0) al = 0;
    end
    r.alpha = al[12:0];
    return r;
  endfunction

  // Random record; mostly particles aged within their lifetime.
  function automatic particle_t random_particle();
    particle_t p;
    int pick;
    pick = $urandom_range(0, 9);
    p.lifetime = (pick < 7) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
    if (pick < 8)
      p.age = 16'($urandom_range(0, p.lifetime));
    else
      p.age = 16'($urandom);
    p.vel = 48'({$urandom, $urandom});
    p.pos = 48'({$urandom, $urandom});
    if ($urandom_range(0, 1)) begin
      p.vel = {3{16'($urandom_range(0, 2000) - 1000)}} ^ 48'($urandom_range(0, 255));
      p.pos = {3{16'($urandom_range(0, 2000) - 1000)}} ^ 48'($urandom_range(0, 255));
    end
    p.ang = 24'($urandom);
    p.rate = 24'($urandom);
    p.full = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1024));
    p.size = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, p.full));
    p.alpha = $urandom_range(0, 7) == 0 ? 13'($urandom) : 13'($urandom_range(0, 4096));
    return p;
  endfunction

  // One register write; valid stays up for the caller to lower.
  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FRAME_TIME:  frame_time = data;
      REG_ACCEL_X:     accel[0] = data;
      REG_ACCEL_Y:     accel[1] = data;
      REG_ACCEL_Z:     accel[2] = data;
      REG_GROW_TIME:   grow_time = data;
      REG_SHRINK_TIME: shrink_time = data;
      REG_FADE_TIME:   fade_time = data;
      default: ;
    endcase
  endtask

  // Wait for the pipeline to empty, then load a full register set.
  task automatic load_settings(logic [15:0] dt, logic [15:0] ax, logic [15:0] ay,
                               logic [15:0] az, logic [15:0] gt, logic [15:0] st,
                               logic [15:0] ft);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    write_reg(REG_FRAME_TIME, dt);
    write_reg(REG_ACCEL_X, ax);
    write_reg(REG_ACCEL_Y, ay);
    write_reg(REG_ACCEL_Z, az);
    write_reg(REG_GROW_TIME, gt);
    write_reg(REG_SHRINK_TIME, st);
    write_reg(REG_FADE_TIME, ft);
    write_reg(REG_UNMAPPED, 16'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Present one record and wait for its transfer.
  task automatic send_particle(particle_t p);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_age <= p.age;
    in_lifetime <= p.lifetime;
    in_velocity <= p.vel;
    in_position <= p.pos;
    in_angle <= p.ang;
    in_angular_rate <= p.rate;
    in_size <= p.size;
    in_full_size <= p.full;
    in_alpha <= p.alpha;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_updates.push_back(predict_update(p));
  endtask

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_updates.size() == 0) begin
        $error("result transfer with no update pending");
        errors++;
      end else begin
        update_t e;
        e = pending_updates.pop_front();
        if (out_alive !== e.alive) begin
          $error("alive: expected %0d, got %0d", e.alive, out_alive); errors++;
        end
        if (out_new_age !== e.age) begin
          $error("new_age: expected %h, got %h", e.age, out_new_age); errors++;
        end
        if (out_new_velocity !== e.vel) begin
          $error("new_velocity: expected %h, got %h", e.vel, out_new_velocity); errors++;
        end
        if (out_new_position !== e.pos) begin
          $error("new_position: expected %h, got %h", e.pos, out_new_position); errors++;
        end
        if (out_new_angle !== e.ang) begin
          $error("new_angle: expected %h, got %h", e.ang, out_new_angle); errors++;
        end
        if (out_new_size !== e.size) begin
          $error("new_size: expected %h, got %h", e.size, out_new_size); errors++;
        end
        if (out_new_alpha !== e.alpha) begin
          $error("new_alpha: expected %h, got %h", e.alpha, out_new_alpha); errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("particle_state_update_top test failed");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    update_t got;
    int phase;

    errors = 0;
    idle_cycles = 0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_age = '0; in_lifetime = '0; in_velocity = '0; in_position = '0;
    in_angle = '0; in_angular_rate = '0; in_size = '0; in_full_size = '0;
    in_alpha = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    frame_time = 16'd16; grow_time = '0; shrink_time = '0; fade_time = '0;
    accel[0] = '0; accel[1] = '0; accel[2] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at reset settings (dt = 16, no windows, no acceleration).
    // Dead particle with saturated age: everything passes through.
    row.p = '{16'hFFFF, 16'h0000, 48'h123456789ABC, 48'hFEDCBA987654, 24'h800000,
              24'h7FFFFF, 16'hFFFF, 16'h0001, 13'h1FFF};
    row.typed = 1'b1;
    row.r = '{1'b0, 16'hFFFF, 48'h123456789ABC, 48'hFEDCBA987654, 24'h800000,
              16'hFFFF, 13'h1FFF};
    rows.push_back(row);
    // Young particle at rest: size snaps to full size, alpha untouched.
    row.p = '{16'd0, 16'd100, '0, '0, '0, '0, 16'd5, 16'h0100, 13'd4096};
    row.r = '{1'b1, 16'd16, '0, '0, '0, 16'h0100, 13'd4096};
    rows.push_back(row);
    // Positive extremes saturate the angle and the positions.
    row.p = '{16'd0, 16'hFFFF, {3{16'h7FFF}}, {3{16'h7FFF}}, 24'h7FFFFF, 24'h7FFFFF,
              16'h0000, 16'hFFFF, 13'h1FFF};
    row.r = '{1'b1, 16'd16, {3{16'h7FFF}}, {3{16'h7FFF}}, 24'h7FFFFF, 16'hFFFF,
              13'h1FFF};
    rows.push_back(row);
    // Negative extremes saturate the other way.
    row.p = '{16'd10, 16'd26, {3{16'h8000}}, {3{16'h8000}}, 24'h800000, 24'h800000,
              16'hFFFF, 16'h0000, 13'd0};
    row.r = '{1'b1, 16'd26, {3{16'h8000}}, {3{16'h8000}}, 24'h800000, 16'h0000, 13'd0};
    rows.push_back(row);
    // Age one past the lifetime boundary.
    row.typed = 1'b0;
    row.p = '{16'd11, 16'd26, 48'h0001_FFFF_0100, 48'h8001_7FFE_0000, 24'd1,
              -24'sd1, 16'd3, 16'd2, 13'd4097};
    rows.push_back(row);
    row.p = '{16'hFFF0, 16'hFFFF, 48'hAAAA_5555_AAAA, 48'h5555_AAAA_5555, 24'h555555,
              24'hAAAAAA, 16'hAAAA, 16'h5555, 13'h0AAA};
    rows.push_back(row);
    row.p = '{16'hFFF5, 16'hFFFF, 48'h5555_AAAA_5555, 48'hAAAA_5555_AAAA, 24'hAAAAAA,
              24'h555555, 16'h5555, 16'hAAAA, 13'h1555};
    rows.push_back(row);
    for (int k = 0; k < 12; k++) begin
      row.p = random_particle();
      rows.push_back(row);
    end
    foreach (rows[k]) begin
      send_particle(rows[k].p);
      // Typed rows must agree with the predictor too.
      if (rows[k].typed) begin
        got = predict_update(rows[k].p);
        if (got != rows[k].r) begin
          $error("directed row %0d: typed expectation differs from prediction", k);
          errors++;
        end
      end
    end

    // Register settings, extremes first, then random.
    for (phase = 0; phase < 9; phase++) begin
      case (phase)
        0: load_settings(16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF);
        1: load_settings(16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 16'd1, 16'd1, 16'd1);
        2: load_settings(16'd1, 16'hFFFF, 16'd1, 16'd0, 16'd200, 16'd300, 16'd400);
        default: load_settings($urandom_range(0, 4) == 0 ? 16'($urandom)
                                                         : 16'($urandom_range(1, 200)),
                               16'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
                               16'($urandom_range(0, 2000)));
      endcase
      if (phase < 3) begin
        send_gap_pct = 22; recv_stall_pct = 51;
      end else if (phase < 6) begin
        send_gap_pct = 51; recv_stall_pct = 22;
      end else begin
        send_gap_pct = 0; recv_stall_pct = 0;
      end
      for (int k = 0; k < 98; k++) send_particle(random_particle());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0)
      $display("particle_state_update_top test passed");
    else
      $display("particle_state_update_top test failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/psu_pkg.sv
rtl/psu_div.sv
rtl/psu_motion.sv
rtl/particle_state_update_top.sv
tb/tb_particle_state_update_top.sv
